[hw/rtl/ntis_pkg.sv]
package ntis_pkg;

  // Table geometry and time format.
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned TIME_BITS   = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  // Signed search bounds: one bit for the sign, one to hold sums of two bounds.
  localparam int unsigned PTR_W       = CNT_W + 1;

  // Stream payload widths.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_DATA_W   = 64;
  localparam int unsigned OUT_W       = 12;
  localparam int unsigned OUT_DATA_W  = ((OUT_W + 7) / 8) * 8;

  // Command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // Opcodes on the input stream.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                    kind;
    logic signed [TIME_BITS-1:0]  tval;
  } cmd_t;

endpackage

[hw/rtl/ntis_front.sv]
module ntis_front import ntis_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       in_op_i,
  input  logic [TIME_BITS-1:0]  in_time_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output cmd_t                  cmd_o
);

  cmd_t              fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLVL_W-1:0] level_q;
  logic              keep;
  cmd_kind_e         kind;
  logic              push, pop;

  // Map the opcode to a command; the unused opcode is taken and dropped here.
  always_comb begin
    keep = 1'b1;
    kind = CMD_LOAD;
    case (in_op_i)
      OP_LOAD:  kind = CMD_LOAD;
      OP_QUERY: kind = CMD_QUERY;
      OP_CLEAR: kind = CMD_CLEAR;
      default:  keep = 1'b0;
    endcase
  end

  assign in_ready_o  = (level_q != QLVL_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (level_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o && keep;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{kind: kind, tval: $signed(in_time_i)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        level_q <= level_q + 1'b1;
      end else if (pop && !push) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= QLVL_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");
`endif

endmodule

[hw/rtl/ntis_back.sv]
module ntis_back import ntis_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  out_index_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROBE = 3'd1;
  localparam logic [2:0] ST_NB1   = 3'd2;
  localparam logic [2:0] ST_NB2   = 3'd3;
  localparam logic [2:0] ST_NB3   = 3'd4;
  localparam logic [2:0] ST_PICK  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  function automatic logic [TIME_BITS-1:0] time_dist(
    input logic signed [TIME_BITS-1:0] a,
    input logic signed [TIME_BITS-1:0] b
  );
    logic [TIME_BITS-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  logic [2:0]                  state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic signed [PTR_W-1:0]     low_q, low_d, high_q, high_d, mid_q, mid_d;
  logic signed [TIME_BITS-1:0] key_q, key_d;
  logic [TIME_BITS-1:0]        d1_q, d1_d, d2_q, d2_d, d3_q, d3_d;
  logic [OUT_W-1:0]            res_q, res_d, out_q;
  logic                        out_valid_q, out_load;

  logic signed [TIME_BITS-1:0] tbl_mem [TABLE_DEPTH];
  logic signed [TIME_BITS-1:0] rd_data_q;
  logic                        wr_en, rd_en;
  logic [IDX_W-1:0]            wr_addr, rd_addr;

  logic                        step_go;
  logic signed [PTR_W-1:0]     step_l, step_h, step_m, step_hm1;
  logic signed [PTR_W-1:0]     count_s, high_p1, far_idx;
  logic signed [PTR_W-1:0]     lo_m, hi_m;
  logic                        has_next, hit, less;
  logic [TIME_BITS-1:0]        d_cur;

  assign count_s  = $signed({1'b0, count_q});
  assign high_p1  = high_q + PTR_W'(1);
  assign has_next = (high_p1 < count_s);
  assign far_idx  = has_next ? high_p1 : high_q;
  assign step_hm1 = step_h - PTR_W'(1);
  assign hit      = (key_q == rd_data_q);
  assign less     = (key_q < rd_data_q);
  assign lo_m     = (low_q + mid_q - PTR_W'(1)) >>> 1;
  assign hi_m     = (mid_q + PTR_W'(1) + high_q) >>> 1;
  assign d_cur    = time_dist(key_q, rd_data_q);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign wr_addr  = count_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    mid_d       = mid_q;
    key_d       = key_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    d3_d        = d3_q;
    res_d       = res_q;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    step_go     = 1'b0;
    step_l      = low_q;
    step_h      = high_q;
    step_m      = mid_q;

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_LOAD: begin
              if (count_q < CNT_W'(TABLE_DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_CLEAR: count_d = '0;
            CMD_QUERY: begin
              key_d   = cmd_i.tval;
              step_go = 1'b1;
              step_l  = '0;
              step_h  = count_s - PTR_W'(1);
              step_m  = (count_s - PTR_W'(1)) >>> 1;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        if (hit) begin
          res_d   = OUT_W'(mid_q);
          state_d = ST_DONE;
        end else begin
          step_go = 1'b1;
          if (less) begin
            step_l = low_q;
            step_h = mid_q - PTR_W'(1);
            step_m = lo_m;
          end else begin
            step_l = mid_q + PTR_W'(1);
            step_h = high_q;
            step_m = hi_m;
          end
        end
      end
      ST_NB1: begin
        d1_d    = d_cur;
        rd_en   = 1'b1;
        rd_addr = high_q[IDX_W-1:0];
        state_d = ST_NB2;
      end
      ST_NB2: begin
        d2_d = d_cur;
        if (has_next) begin
          rd_en   = 1'b1;
          rd_addr = high_p1[IDX_W-1:0];
          state_d = ST_NB3;
        end else begin
          d3_d    = d_cur;
          state_d = ST_PICK;
        end
      end
      ST_NB3: begin
        d3_d    = d_cur;
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (d1_q < d2_q) begin
          res_d = (d1_q < d3_q) ? OUT_W'(high_q - PTR_W'(1)) : OUT_W'(far_idx);
        end else begin
          res_d = (d2_q < d3_q) ? OUT_W'(high_q) : OUT_W'(far_idx);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // One search step: stop when the upper bound is at or below zero, fetch
    // the neighbors once the bounds meet, otherwise read the next probe.
    if (step_go) begin
      low_d  = step_l;
      high_d = step_h;
      mid_d  = step_m;
      if (step_h[PTR_W-1] || (step_h == PTR_W'(0))) begin
        res_d   = '0;
        state_d = ST_DONE;
      end else if (step_l >= step_h) begin
        rd_en   = 1'b1;
        rd_addr = step_hm1[IDX_W-1:0];
        state_d = ST_NB1;
      end else begin
        rd_en   = 1'b1;
        rd_addr = step_m[IDX_W-1:0];
        state_d = ST_PROBE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= cmd_i.tval;
    end
    if (rd_en) begin
      rd_data_q <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    mid_q  <= mid_d;
    key_q  <= key_d;
    d1_q   <= d1_d;
    d2_q   <= d2_d;
    d3_q   <= d3_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_probe_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (!low_q[PTR_W-1] && (low_q <= mid_q) && (mid_q < high_q)))
    else $error("probe index outside search bounds");

  a_nb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NB1) |-> ((high_q > PTR_W'(0)) && (high_q < count_s)))
    else $error("neighbor fetch outside stored entries");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_load) |=> (state_q == ST_DONE))
    else $error("result dropped while output register busy");
`endif

endmodule

[hw/rtl/nearest_time_index_search_unit.sv]
// Channel   Direction  Transfer content
// s_axis    in         tuser: opcode; tdata: time_value
// m_axis    out        tdata: found_index (low 12 bits, rest zero)
//
// The front takes one transfer per cycle while its two-entry command queue
// has room; opcode 3 is taken and dropped there.
// In the back a load or clear is handled in the idle state. A query is
// dispatched, then takes binary-search probes (at most twelve for 4096
// entries) and, without an exact hit, up to three neighbor reads of the
// single-port table memory and a pick step, then enters the output register.
// Reset empties the queue, the output register and the entry count; the
// table contents are left as they are and are never read before written.
// A stalled m_axis holds the finished result and the back, while the front
// keeps taking transfers until its queue fills.
module nearest_time_index_search_unit import ntis_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata_i,   // [63:0] time_value
  input  logic [OP_W-1:0]        s_axis_tuser_i,   // [1:0] opcode
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata_o    // [11:0] found_index, rest zero
);

  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;
  logic [OUT_W-1:0] found_index;

  // The front classifies incoming transfers and buffers commands.
  ntis_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_time_i   (s_axis_tdata_i[TIME_BITS-1:0]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // The back owns the timestamp table, the entry count and the search.
  ntis_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_index_o (found_index)
  );

  assign m_axis_tdata_o = {{(OUT_DATA_W - OUT_W){1'b0}}, found_index};

endmodule

[bench/nearest_time_index_search_unit_tb.sv]
`timescale 1ns / 100ps

module nearest_time_index_search_unit_tb;
  import ntis_pkg::*;

  // Opcode 3 has no name in the package; the block takes and drops it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [IN_DATA_W-1:0] T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [IN_DATA_W-1:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 820;
  localparam int DRAIN_CYCLES = 40;

  // Mirror of the timestamp table. Each query pushes the index the block
  // should answer with, and results are matched in arrival order.
  class nearest_index_board;
    longint stamps[TABLE_DEPTH];
    int unsigned stored;
    logic [OUT_DATA_W-1:0] pending_index[$];
    int errors;

    function logic [63:0] magnitude(longint a, longint b);
      logic [63:0] diff;
      diff = (a >= b) ? (a - b) : (b - a);
      return diff;
    endfunction

    // Binary search, then a pick among the entries around the final upper
    // bound. Ties go to the later entry because every compare is strict.
    function logic [IDX_W-1:0] nearest_of(longint t);
      int lo;
      int hi;
      int mid;
      int far_idx;
      bit has_next;
      longint t3;
      logic [63:0] d1;
      logic [63:0] d2;
      logic [63:0] d3;
      lo = 0;
      hi = int'(stored) - 1;
      while (1) begin
        if (hi <= 0) return '0;
        if (lo >= hi) begin
          has_next = (hi + 1) < int'(stored);
          t3 = has_next ? stamps[hi+1] : stamps[hi];
          d1 = magnitude(t, stamps[hi-1]);
          d2 = magnitude(t, stamps[hi]);
          d3 = magnitude(t, t3);
          far_idx = has_next ? hi + 1 : hi;
          if (d1 < d2) return (d1 < d3) ? IDX_W'(hi - 1) : IDX_W'(far_idx);
          return (d2 < d3) ? IDX_W'(hi) : IDX_W'(far_idx);
        end
        mid = (lo + hi) / 2;
        if (t == stamps[mid]) return IDX_W'(mid);
        if (t < stamps[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
    endfunction

    function void take_item(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] raw);
      longint t;
      t = raw;
      case (op)
        OP_LOAD: begin
          if (stored < TABLE_DEPTH) begin
            stamps[stored] = t;
            stored++;
          end
        end
        OP_QUERY: begin
          pending_index.push_back({{(OUT_DATA_W-IDX_W){1'b0}}, nearest_of(t)});
        end
        OP_CLEAR: begin
          stored = 0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_index(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      if (pending_index.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = pending_index.pop_front();
      if (got !== want) begin
        $display("%0t: found_index mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  nearest_index_board board = new();
  bit tx_quiet;
  int hold_off_cycles;
  int sent_items;

  nearest_time_index_search_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offers one transfer after a random gap and returns at the edge that
  // accepts it. tvalid stays high into the next item when it has no gap.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] t);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= t;
    do @(posedge clk); while (!s_tready);
    board.take_item(op, t);
    if (op != OP_UNUSED) sent_items++;
  endtask

  // Query time: mostly an entry of the table, exact, slightly off or further
  // off, else anywhere in the signed range.
  function automatic logic [IN_DATA_W-1:0] probe_time();
    longint base;
    if (board.stored == 0 || $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: return T_MIN;
        1: return T_MAX;
        2: return '0;
        default: return {$urandom, $urandom};
      endcase
    end
    base = board.stamps[$urandom_range(0, board.stored - 1)];
    case ($urandom_range(0, 2))
      0: return base;
      1: return base + longint'($urandom_range(0, 16)) - 8;
      default: return base + longint'($urandom) - longint'($urandom);
    endcase
  endfunction

  // A run of loads: sorted wide values, sorted clusters with repeats and
  // ties, sorted scaled steps, or plain unordered values.
  task automatic load_run(input int n);
    longint vals[$];
    longint base;
    int style;
    int shift;
    style = $urandom_range(0, 3);
    shift = $urandom_range(0, 40);
    base = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      case (style)
        1: vals.push_back(longint'($urandom_range(0, 40)) - 20);
        2: vals.push_back(base + (longint'($urandom_range(0, 63)) <<< shift));
        default: vals.push_back({$urandom, $urandom});
      endcase
    end
    if (style != 3) vals.sort();
    foreach (vals[i]) send_item(OP_LOAD, vals[i]);
  endtask

  // Result side: random stalls, quiet stretches, and a long hold-off when
  // the stimulus asks for one.
  initial begin
    int gap;
    bit rx_quiet;
    rx_quiet = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 13);
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_index(m_tdata);
    end
  end

  initial begin
    #40_000_000;
    $display("nearest_time_index_search_unit test failed");
    $finish;
  end

  initial begin
    int n;
    int start_count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty and single-entry tables, range extremes, exact hits,
    // repeated entries, equal-distance ties, the dropped opcode, clear, and
    // an unordered table.
    send_item(OP_QUERY, '0);
    send_item(OP_UNUSED, '1);
    send_item(OP_LOAD, T_MIN);
    send_item(OP_QUERY, T_MAX);
    send_item(OP_LOAD, 64'hFFFF_FFFF_0000_0000);
    send_item(OP_LOAD, 64'd0);
    send_item(OP_LOAD, 64'd0);
    send_item(OP_LOAD, 64'd10);
    send_item(OP_LOAD, 64'd20);
    send_item(OP_LOAD, T_MAX);
    send_item(OP_QUERY, T_MIN);
    send_item(OP_QUERY, T_MAX);
    send_item(OP_QUERY, 64'd5);
    send_item(OP_QUERY, 64'd15);
    send_item(OP_QUERY, 64'd0);
    send_item(OP_QUERY, '1);
    send_item(OP_QUERY, 64'h4000_0000_0000_0000);
    send_item(OP_CLEAR, '1);
    send_item(OP_QUERY, 64'd7);
    send_item(OP_LOAD, 64'd50);
    send_item(OP_LOAD, 64'd10);
    send_item(OP_LOAD, 64'd30);
    send_item(OP_QUERY, 64'd25);
    send_item(OP_QUERY, 64'd10);

    // Random phases: mostly a fresh table followed by a batch of queries.
    start_count = sent_items;
    for (int phase = 0; sent_items - start_count < RANDOM_ITEMS; phase++) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) send_item(OP_CLEAR, {$urandom, $urandom});
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 1);
        1: n = $urandom_range(25, 200);
        default: n = $urandom_range(2, 24);
      endcase
      load_run(n);
      if (phase % 15 == 5) begin
        // Hold the result side off while queries keep coming back to back,
        // so the command queue fills and the input stalls.
        hold_off_cycles = 300;
        tx_quiet = 1'b1;
        repeat (24) send_item(OP_QUERY, probe_time());
      end else begin
        n = $urandom_range(2, 10);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) send_item(OP_UNUSED, {$urandom, $urandom});
          send_item(OP_QUERY, probe_time());
        end
      end
    end
    s_tvalid <= 1'b0;

    while (board.pending_index.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_index.size() == 0) begin
      $display("nearest_time_index_search_unit test passed");
    end else begin
      $display("nearest_time_index_search_unit test failed");
    end
    $finish;
  end

endmodule
